[sv/cbs_pkg.sv]
// cbs_pkg: shared constants, bar transaction type, signal codes and sequencer states
// for the channel breakout signal block. No dependencies.
`default_nettype none
package cbs_pkg;

	localparam int LOOKBACK_MAX = 64;
	localparam int PRICE_BITS   = 32;
	localparam int TIME_BITS    = 63;
	localparam int LB_BITS      = 7;
	localparam int INT_BITS     = 8;
	localparam int FRAC_BITS    = 16;
	localparam int STR_BITS     = INT_BITS + FRAC_BITS;

	localparam int CNT_W = $clog2(LOOKBACK_MAX + 1);
	localparam int IDX_W = (LOOKBACK_MAX > 1) ? $clog2(LOOKBACK_MAX) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LB_BITS-1:0]    LOOKBACK_RESET = LB_BITS'(20);
	localparam logic [STR_BITS-1:0]   STR_MAX        = '1;
	localparam logic [PRICE_BITS-1:0] PRICE_MAX      = '1;

	typedef enum logic [1:0] {
		KIND_HOLD      = 2'd0,
		KIND_LONG      = 2'd1,
		KIND_SHORT     = 2'd2,
		KIND_NOT_READY = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP,
		ST_DIV,
		ST_FINISH
	} back_state_t;

	typedef struct packed {
		logic [PRICE_BITS-1:0] hi;
		logic [PRICE_BITS-1:0] lo;
		logic [PRICE_BITS-1:0] cl;
		logic [TIME_BITS-1:0]  tm;
		logic                  ready;
		logic [CNT_W-1:0]      n;
	} bar_item_t;

endpackage
`default_nettype wire

[sv/cbs_front.sv]
// cbs_front: accepts bar transactions, holds the lookback register and the bar count,
// and tags each bar with its effective lookback and readiness. Depends on cbs_pkg.
`default_nettype none
module cbs_front import cbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [LB_BITS-1:0]    cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PRICE_BITS-1:0] bar_high,
	input  wire logic [PRICE_BITS-1:0] bar_low,
	input  wire logic [PRICE_BITS-1:0] close_price,
	input  wire logic [TIME_BITS-1:0]  bar_time,
	input  wire logic                  q_full,
	output logic                       push,
	output bar_item_t                  item
);

	logic [LB_BITS-1:0] lookback_q;
	logic [CNT_W-1:0]   bars_q;
	logic [CNT_W-1:0]   n_eff;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		if (lookback_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(lookback_q) > LOOKBACK_MAX) begin
			n_eff = CNT_W'(LOOKBACK_MAX);
		end else begin
			n_eff = CNT_W'(lookback_q);
		end
	end

	always_comb begin
		item.hi    = bar_high;
		item.lo    = bar_low;
		item.cl    = close_price;
		item.tm    = bar_time;
		item.n     = n_eff;
		item.ready = (bars_q >= n_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookback_q <= LOOKBACK_RESET;
			bars_q     <= '0;
		end else begin
			if (cfg_we) begin
				lookback_q <= cfg_wdata;
			end
			if (push && (bars_q != CNT_W'(LOOKBACK_MAX))) begin
				bars_q <= bars_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[sv/cbs_queue.sv]
// cbs_queue: short FIFO of tagged bar transactions between front and back.
// Depends on cbs_pkg.
`default_nettype none
module cbs_queue import cbs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  bar_item_t push_item,
	input  wire logic pop,
	output logic      full,
	output logic      q_valid,
	output bar_item_t q_item
);

	bar_item_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[sv/cbs_div.sv]
// cbs_div: radix-2 restoring divider giving diff/den as saturated unsigned Q8.16,
// one quotient bit per cycle. Depends on cbs_pkg.
`default_nettype none
module cbs_div import cbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [PRICE_BITS-1:0] diff,
	input  wire logic [PRICE_BITS-1:0] den,
	output logic                       done,
	output logic [STR_BITS-1:0]        quot
);

	localparam int SCNT_W = $clog2(STR_BITS + 1);

	logic                    busy_q;
	logic                    done_q;
	logic [SCNT_W-1:0]       cnt_q;
	logic [PRICE_BITS-1:0]   rem_q;
	logic [PRICE_BITS-1:0]   den_q;
	logic [STR_BITS-1:0]     sh_q;
	logic [STR_BITS-1:0]     quot_q;
	logic [PRICE_BITS:0]     rem_sh;
	logic                    ge;
	logic [PRICE_BITS:0]     rem_sub;
	logic                    sat;

	assign done = done_q;
	assign quot = quot_q;

	// quotient of 256 or more, or a zero divisor, saturates
	assign sat     = (den == '0) ||
	                 ({{INT_BITS{1'b0}}, diff} >= {den, {INT_BITS{1'b0}}});
	assign rem_sh  = {rem_q, sh_q[STR_BITS-1]};
	assign ge      = (rem_sh >= {1'b0, den_q});
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= PRICE_BITS'(diff >> INT_BITS);
			sh_q   <= {diff[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
			quot_q <= sat ? STR_MAX : '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[PRICE_BITS-1:0] : rem_sh[PRICE_BITS-1:0];
			sh_q   <= {sh_q[STR_BITS-2:0], 1'b0};
			quot_q <= {quot_q[STR_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				done_q <= sat;
				cnt_q  <= SCNT_W'(STR_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

[sv/cbs_back.sv]
// cbs_back: sequencer holding the high and low rings, scanning the channel, classifying
// the close, driving the divider and the output register. Depends on cbs_pkg, cbs_div.
`default_nettype none
module cbs_back import cbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  bar_item_t                  q_item,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 signal_kind,
	output logic [STR_BITS-1:0]        strength,
	output logic [PRICE_BITS-1:0]      channel_high,
	output logic [PRICE_BITS-1:0]      channel_low,
	output logic [TIME_BITS-1:0]       signal_time
);

	typedef struct packed {
		logic pop;
		logic issue;
		logic div_start;
		logic ring_we;
	} back_ctl_t;

	back_state_t            state_q, state_d;
	back_ctl_t              ctl;

	logic [PRICE_BITS-1:0]  high_mem [LOOKBACK_MAX];
	logic [PRICE_BITS-1:0]  low_mem  [LOOKBACK_MAX];

	bar_item_t              cur_q;
	logic [IDX_W-1:0]       head_q;
	logic [IDX_W-1:0]       addr_q;
	logic [CNT_W-1:0]       issued_q;
	logic                   rd_vld_q;
	logic [PRICE_BITS-1:0]  rd_high_q;
	logic [PRICE_BITS-1:0]  rd_low_q;
	logic [PRICE_BITS-1:0]  highest_q;
	logic [PRICE_BITS-1:0]  lowest_q;
	kind_t                  kind_q;
	logic [STR_BITS-1:0]    str_q;

	logic                   out_valid_q;
	kind_t                  out_kind_q;
	logic [STR_BITS-1:0]    out_str_q;
	logic [PRICE_BITS-1:0]  out_ch_q;
	logic [PRICE_BITS-1:0]  out_cl_q;
	logic [TIME_BITS-1:0]   out_time_q;

	logic                   scan_more;
	logic                   is_long;
	logic                   is_short;
	logic                   out_free;
	logic                   load;
	logic [PRICE_BITS-1:0]  div_diff;
	logic [PRICE_BITS-1:0]  div_den;
	logic                   div_done;
	logic [STR_BITS-1:0]    div_quot;

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		idx_dec = (i == '0) ? IDX_W'(LOOKBACK_MAX - 1) : i - 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		idx_inc = (i == IDX_W'(LOOKBACK_MAX - 1)) ? '0 : i + 1'b1;
	endfunction

	assign scan_more = (issued_q != cur_q.n);
	assign is_long   = (cur_q.cl > highest_q);
	assign is_short  = !is_long && (cur_q.cl < lowest_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign load      = (state_q == ST_FINISH) && out_free;
	assign div_diff  = is_long ? (cur_q.cl - highest_q) : (lowest_q - cur_q.cl);
	assign div_den   = is_long ? highest_q : lowest_q;
	assign pop       = ctl.pop;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = q_item.ready ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (!scan_more && !rd_vld_q) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = (is_long || is_short) ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.pop = q_valid;
			end
			ST_SCAN: begin
				ctl.issue = scan_more;
			end
			ST_CMP: begin
				ctl.div_start = is_long || is_short;
			end
			ST_FINISH: begin
				ctl.ring_we = out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	cbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.diff   (div_diff),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (ctl.ring_we) begin
			high_mem[head_q] <= cur_q.hi;
			low_mem[head_q]  <= cur_q.lo;
		end
		if (ctl.issue) begin
			rd_high_q <= high_mem[addr_q];
			rd_low_q  <= low_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			cur_q     <= q_item;
			addr_q    <= idx_dec(head_q);
			highest_q <= '0;
			lowest_q  <= PRICE_MAX;
			kind_q    <= KIND_NOT_READY;
			str_q     <= '0;
		end
		if (ctl.issue) begin
			addr_q <= idx_dec(addr_q);
		end
		if (rd_vld_q) begin
			if (rd_high_q > highest_q) begin
				highest_q <= rd_high_q;
			end
			if (rd_low_q < lowest_q) begin
				lowest_q <= rd_low_q;
			end
		end
		if (state_q == ST_CMP) begin
			kind_q <= is_long ? KIND_LONG : (is_short ? KIND_SHORT : KIND_HOLD);
		end
		if ((state_q == ST_DIV) && div_done) begin
			str_q <= div_quot;
		end
		if (load) begin
			out_kind_q <= kind_q;
			out_str_q  <= str_q;
			out_ch_q   <= (kind_q == KIND_NOT_READY) ? '0 : highest_q;
			out_cl_q   <= (kind_q == KIND_NOT_READY) ? '0 : lowest_q;
			out_time_q <= cur_q.tm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			issued_q    <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= ctl.issue;
			if (ctl.pop) begin
				issued_q <= '0;
			end else if (ctl.issue) begin
				issued_q <= issued_q + 1'b1;
			end
			if (ctl.ring_we) begin
				head_q <= idx_inc(head_q);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign signal_kind  = out_kind_q;
	assign strength     = out_str_q;
	assign channel_high = out_ch_q;
	assign channel_low  = out_cl_q;
	assign signal_time  = out_time_q;

	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> (state_q == ST_SCAN))
		else $error("ring read data outside scan");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issued_q <= cur_q.n))
		else $error("scan issued more reads than lookback");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_head_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ring_we |=> (head_q == idx_inc($past(head_q))))
		else $error("ring head did not advance by one");

	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load && (kind_q == KIND_NOT_READY) |=>
		(out_str_q == '0) && (out_ch_q == '0) && (out_cl_q == '0))
		else $error("not-ready signal carries non-zero fields");

endmodule
`default_nettype wire

[sv/channel_breakout_signal.sv]
// channel_breakout_signal: top level of the channel breakout signal block.
// Depends on cbs_pkg, cbs_front, cbs_queue, cbs_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------------
//   bar in   | in_valid / in_stall | bar_high, bar_low, close_price, bar_time
//   signal   | out_valid/out_stall | signal_kind, strength, channel_high,
//            |                     | channel_low, signal_time
//   config   | cfg_we              | cfg_wdata (lookback)
//
// Pop to output load: a not-ready bar goes from ST_IDLE to ST_FINISH; a ready bar, hold, passes
// ST_SCAN, the channel scan reading one ring entry per cycle, ST_CMP and ST_FINISH. A breakout
// adds ST_DIV, the divider adding one quotient bit per cycle unless strength saturates.
// A two-entry queue lets bars be taken while the back end scans or waits on out_stall.
// arst_n clears control state only; the rings need no clearing.
`default_nettype none
module channel_breakout_signal import cbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [LB_BITS-1:0]    cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PRICE_BITS-1:0] bar_high,
	input  wire logic [PRICE_BITS-1:0] bar_low,
	input  wire logic [PRICE_BITS-1:0] close_price,
	input  wire logic [TIME_BITS-1:0]  bar_time,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 signal_kind,
	output logic [STR_BITS-1:0]        strength,
	output logic [PRICE_BITS-1:0]      channel_high,
	output logic [PRICE_BITS-1:0]      channel_low,
	output logic [TIME_BITS-1:0]       signal_time
);

	logic      push;
	logic      q_full;
	logic      q_valid;
	logic      pop;
	bar_item_t push_item;
	bar_item_t q_item;

	cbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.bar_high    (bar_high),
		.bar_low     (bar_low),
		.close_price (close_price),
		.bar_time    (bar_time),
		.q_full      (q_full),
		.push        (push),
		.item        (push_item)
	);

	cbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	cbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.signal_kind  (signal_kind),
		.strength     (strength),
		.channel_high (channel_high),
		.channel_low  (channel_low),
		.signal_time  (signal_time)
	);

endmodule
`default_nettype wire
